### hw/rtl/lesdp_pkg.sv
`default_nettype none

package lesdp_pkg;

	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	localparam int CHAR_W  = 8;
	localparam int DIM_W   = 11;
	localparam int SIDE_W  = 11;
	localparam int COORD_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	typedef logic [CHAR_W-1:0]     char_t;
	typedef logic [DIM_W-1:0]      dim_t;
	typedef logic [SIDE_W-1:0]     side_t;
	typedef logic [COORD_W-1:0]    coord_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OBSTACLE = 2'd0,
		REG_ROWS     = 2'd1,
		REG_COLS     = 2'd2
	} cfg_reg_t;

	localparam char_t OBSTACLE_RST = 8'd111;
	localparam dim_t  ROWS_RST     = 11'd1;
	localparam dim_t  COLS_RST     = 11'd1;

endpackage

`default_nettype wire

### hw/rtl/lesdp_if.sv
`default_nettype none

interface lesdp_cell_if;
	logic                 valid;
	logic                 ready;
	lesdp_pkg::char_t     cell_char;

	modport source (output valid, output cell_char, input ready);
	modport sink   (input valid, input cell_char, output ready);
endinterface

interface lesdp_result_if;
	logic                 valid;
	logic                 ready;
	lesdp_pkg::side_t     best_side;
	lesdp_pkg::coord_t    top_row;
	lesdp_pkg::coord_t    left_col;

	modport source (output valid, output best_side, output top_row, output left_col,
		input ready);
	modport sink   (input valid, input best_side, input top_row, input left_col,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/lesdp_line_buf.sv
`default_nettype none

// One row of scores: one write and one registered read per cycle.
module lesdp_line_buf #(
	parameter int DEPTH = lesdp_pkg::MAX_COLS_DEF,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] ram [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= ram[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/largest_empty_square_dp.sv
// Largest obstacle-free square over a byte grid streamed in raster order.
//
// grid_cell : one grid byte per beat, row by row. cell_char equal to the
//             obstacle register marks a blocked cell.
// result    : one beat after the last cell of each grid: side of the largest
//             free square (0 if none) and its top-left row and column. On a
//             tie the square found first in raster order is kept.
// cfg       : write-only registers (obstacle byte, row count, column count),
//             changed only while no grid is in progress. The user must keep
//             to this; the block has no check for it. Counts of 0 act as 1,
//             counts above the build maximum act as the maximum.
// Throughput is one cell per cycle. The last cell is scored in stage 1 after
// its line-buffer read and, unless stalled, loaded into the output register.
// The line buffer is read at the cell's column as it is taken and written
// back when it leaves stage 1; a cell reading the entry still being written
// takes it from a bypass register. Reset clears position, neighbor scores,
// best score and output valid; the line buffer is not cleared and needs no
// setup time. If the receiver stalls on a result, cells flow until a second
// result is ready; then grid_cell.ready drops until the first is taken.
`default_nettype none

module largest_empty_square_dp #(
	parameter int MAX_COLS = lesdp_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lesdp_pkg::MAX_ROWS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [lesdp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire lesdp_pkg::cfg_data_t        cfg_data,
	lesdp_cell_if.sink                       grid_cell,
	lesdp_result_if.source                   result
);

	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNW = ($clog2(MAX_COLS + 1) > lesdp_pkg::DIM_W) ?
		$clog2(MAX_COLS + 1) : lesdp_pkg::DIM_W;
	localparam int RNW = ($clog2(MAX_ROWS + 1) > lesdp_pkg::DIM_W) ?
		$clog2(MAX_ROWS + 1) : lesdp_pkg::DIM_W;
	localparam int MIN_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int SW = $clog2(MIN_DIM + 1);
	localparam int RDW = ((RIW > SW) ? RIW : SW) + 1;
	localparam int CDW = ((CIW > SW) ? CIW : SW) + 1;

	// configuration
	lesdp_pkg::char_t obstacle_q;
	lesdp_pkg::dim_t  grid_rows_q;
	lesdp_pkg::dim_t  grid_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_q  <= lesdp_pkg::OBSTACLE_RST;
			grid_rows_q <= lesdp_pkg::ROWS_RST;
			grid_cols_q <= lesdp_pkg::COLS_RST;
		end else if (cfg_we) begin
			case (lesdp_pkg::cfg_reg_t'(cfg_index))
				lesdp_pkg::REG_OBSTACLE: obstacle_q  <= lesdp_pkg::char_t'(cfg_data);
				lesdp_pkg::REG_ROWS:     grid_rows_q <= lesdp_pkg::dim_t'(cfg_data);
				lesdp_pkg::REG_COLS:     grid_cols_q <= lesdp_pkg::dim_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// effective grid size
	logic [RNW-1:0] rows_ext, rows_eff;
	logic [CNW-1:0] cols_ext, cols_eff;

	always_comb begin
		rows_ext = RNW'(grid_rows_q);
		cols_ext = CNW'(grid_cols_q);
		if (rows_ext == '0) begin
			rows_eff = RNW'(1);
		end else if (rows_ext > RNW'(MAX_ROWS)) begin
			rows_eff = RNW'(MAX_ROWS);
		end else begin
			rows_eff = rows_ext;
		end
		if (cols_ext == '0) begin
			cols_eff = CNW'(1);
		end else if (cols_ext > CNW'(MAX_COLS)) begin
			cols_eff = CNW'(MAX_COLS);
		end else begin
			cols_eff = cols_ext;
		end
	end

	// stage 0: position of the incoming cell, line-buffer read
	logic [RIW-1:0] row_q;
	logic [CIW-1:0] col_q;
	logic           accept;
	logic           stall;
	logic           commit;
	logic           col_last, row_last;

	assign accept   = grid_cell.valid && grid_cell.ready;
	assign col_last = (CNW'(col_q) + CNW'(1)) >= cols_eff;
	assign row_last = (RNW'(row_q) + RNW'(1)) >= rows_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (!col_last) begin
				col_q <= col_q + CIW'(1);
			end else begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RIW'(1);
			end
		end
	end

	// stage 1 pipeline registers
	logic           valid_s1;
	logic           obst_s1;
	logic           border_s1;
	logic           fwd_s1;
	logic           row_end_s1;
	logic           grid_end_s1;
	logic [CIW-1:0] col_s1;
	logic [RIW-1:0] row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			obst_s1     <= (grid_cell.cell_char == obstacle_q);
			border_s1   <= (row_q == '0) || (col_q == '0);
			// previous cell writes this entry on the same edge: bypass the RAM
			fwd_s1      <= valid_s1 && (col_s1 == col_q);
			row_end_s1  <= col_last;
			grid_end_s1 <= col_last && row_last;
			col_s1      <= col_q;
			row_s1      <= row_q;
		end
	end

	// line buffer
	logic [SW-1:0] rd_data;
	logic [SW-1:0] score;

	lesdp_line_buf #(
		.DEPTH (MAX_COLS),
		.AW    (CIW),
		.DW    (SW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (commit),
		.wr_addr (col_s1),
		.wr_data (score)
	);

	// stage 1: score, best tracking
	logic [SW-1:0]  last_q;
	logic [SW-1:0]  left_q, diag_q;
	logic [SW-1:0]  best_q;
	logic [RIW-1:0] best_row_q;
	logic [CIW-1:0] best_col_q;
	logic [SW-1:0]  upper, min3;
	logic [SW-1:0]  nb_score;
	logic [RIW-1:0] nb_row;
	logic [CIW-1:0] nb_col;
	logic [RDW-1:0] top_full;
	logic [CDW-1:0] left_full;
	logic           out_valid_q;

	assign stall  = valid_s1 && grid_end_s1 && out_valid_q && !result.ready;
	assign commit = valid_s1 && !stall;
	assign grid_cell.ready = !stall;

	always_comb begin
		upper = fwd_s1 ? last_q : rd_data;
		min3  = upper;
		if (left_q < min3) begin
			min3 = left_q;
		end
		if (diag_q < min3) begin
			min3 = diag_q;
		end
		if (obst_s1) begin
			score = '0;
		end else if (border_s1) begin
			score = SW'(1);
		end else begin
			score = min3 + SW'(1);
		end
		if (score > best_q) begin
			nb_score = score;
			nb_row   = row_s1;
			nb_col   = col_s1;
		end else begin
			nb_score = best_q;
			nb_row   = best_row_q;
			nb_col   = best_col_q;
		end
		top_full  = RDW'(nb_row) + RDW'(1) - RDW'(nb_score);
		left_full = CDW'(nb_col) + CDW'(1) - CDW'(nb_score);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			diag_q     <= '0;
			best_q     <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (commit) begin
			if (row_end_s1) begin
				left_q <= '0;
				diag_q <= '0;
			end else begin
				left_q <= score;
				diag_q <= upper;
			end
			if (grid_end_s1) begin
				best_q     <= '0;
				best_row_q <= '0;
				best_col_q <= '0;
			end else begin
				best_q     <= nb_score;
				best_row_q <= nb_row;
				best_col_q <= nb_col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			last_q <= score;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && grid_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && grid_end_s1) begin
			result.best_side <= lesdp_pkg::side_t'(nb_score);
			if (nb_score == '0) begin
				result.top_row  <= '0;
				result.left_col <= '0;
			end else begin
				result.top_row  <= lesdp_pkg::coord_t'(top_full);
				result.left_col <= lesdp_pkg::coord_t'(left_full);
			end
		end
	end

	assign result.valid = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/lesdp_checker.sv
`default_nettype none

module lesdp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire lesdp_pkg::side_t  best_side,
	input wire lesdp_pkg::coord_t top_row,
	input wire lesdp_pkg::coord_t left_col
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_side) &&
			$stable(top_row) && $stable(left_col))
		else $error("result beat changed while stalled");

	// no square means a zero corner
	a_zero_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (best_side == '0) |-> (top_row == '0) && (left_col == '0))
		else $error("empty result with nonzero corner");

	// a fresh result rises only after a taken cell
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a cell two cycles before");

	// the square's top row plus its side never exceeds 2048
	a_corner_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (best_side != '0) |->
			({1'b0, top_row} + {1'b0, best_side}) <= 12'd2048)
		else $error("square corner out of range");

endmodule

bind largest_empty_square_dp lesdp_checker u_lesdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (grid_cell.valid),
	.in_ready  (grid_cell.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.best_side (result.best_side),
	.top_row   (result.top_row),
	.left_col  (result.left_col)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import lesdp_pkg::*;

	typedef struct packed {
		side_t  side;
		coord_t row;
		coord_t col;
	} square_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	cfg_reg_t  cfg_index;
	cfg_data_t cfg_data;

	lesdp_cell_if   cell_if ();
	lesdp_result_if res_if ();

	largest_empty_square_dp dut (clk, arst_n, cfg_we, cfg_index, cfg_data, cell_if, res_if);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register copies and scan state of the predictor
	char_t  cfg_obstacle = OBSTACLE_RST;
	dim_t   cfg_rows     = ROWS_RST;
	dim_t   cfg_cols     = COLS_RST;
	side_t  above_row [MAX_COLS_DEF] = '{default: '0};
	side_t  left_s = '0, diag_s = '0, peak = '0;
	coord_t cur_row = '0, cur_col = '0, peak_row = '0, peak_col = '0;

	square_t squares_due [$];
	int      mismatches = 0;
	int      cells_sent = 0;
	bit      idle_on = 1'b1;

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	function automatic int dim_eff(input dim_t v, input int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// score one cell; returns 1 with the square when the cell closes the grid
	function automatic bit score_cell(input char_t c, output square_t sq);
		int rows, cols, slot, up, s;
		rows = dim_eff(cfg_rows, MAX_ROWS_DEF);
		cols = dim_eff(cfg_cols, MAX_COLS_DEF);
		slot = (cur_col < MAX_COLS_DEF) ? cur_col : MAX_COLS_DEF - 1;
		up = above_row[slot];
		sq = '0;
		if (c == cfg_obstacle)
			s = 0;
		else if (cur_row == 0 || cur_col == 0)
			s = 1;
		else begin
			s = up;
			if (left_s < s)
				s = left_s;
			if (diag_s < s)
				s = diag_s;
			s++;
		end
		// strict compare: a tie keeps the earlier cell
		if (s > peak) begin
			peak = side_t'(s);
			peak_row = cur_row;
			peak_col = cur_col;
		end
		diag_s = side_t'(up);
		above_row[slot] = side_t'(s);
		left_s = side_t'(s);
		if (cur_col + 1 < cols) begin
			cur_col++;
			return 0;
		end
		cur_col = '0;
		left_s = '0;
		diag_s = '0;
		if (cur_row + 1 < rows) begin
			cur_row++;
			return 0;
		end
		sq.side = peak;
		if (peak != 0) begin
			sq.row = coord_t'(peak_row + 1 - peak);
			sq.col = coord_t'(peak_col + 1 - peak);
		end
		cur_row = '0;
		peak = '0;
		peak_row = '0;
		peak_col = '0;
		return 1;
	endfunction

	task automatic set_config(input char_t obs, input dim_t rows, input dim_t cols);
		cfg_we <= 1'b1;
		cfg_index <= REG_OBSTACLE;
		cfg_data <= cfg_data_t'(obs);
		@(posedge clk);
		cfg_obstacle = obs;
		cfg_index <= REG_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		cfg_rows = rows;
		cfg_index <= REG_COLS;
		cfg_data <= cols;
		@(posedge clk);
		cfg_cols = cols;
		cfg_we <= 1'b0;
	endtask

	task automatic send_cell(input char_t c);
		square_t sq;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			cell_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		cell_if.valid <= 1'b1;
		cell_if.cell_char <= c;
		do @(posedge clk); while (!cell_if.ready);
		cells_sent++;
		if (score_cell(c, sq))
			squares_due.push_back(sq);
	endtask

	task automatic send_grid(input int blocked_pct);
		int n;
		n = dim_eff(cfg_rows, MAX_ROWS_DEF) * dim_eff(cfg_cols, MAX_COLS_DEF);
		repeat (n)
			send_cell(($urandom_range(0, 99) < blocked_pct) ? cfg_obstacle :
				char_t'($urandom_range(0, 255)));
	endtask

	// hold the sender until every square is back or the wait runs out, then let the pipe settle
	task automatic drain();
		int waited;
		waited = 0;
		cell_if.valid <= 1'b0;
		while (squares_due.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (6) @(posedge clk);
	endtask

	function automatic dim_t pick_dim();
		case ($urandom_range(0, 15))
			0: return dim_t'(0);
			1: return dim_t'(1);
			2: return dim_t'($urandom_range(11, 32));
			default: return dim_t'($urandom_range(1, 10));
		endcase
	endfunction

	task automatic test_reset_values();
		// obstacle 111 and a 1x1 grid straight out of reset
		send_cell(8'd111);
		send_cell(8'd0);
		send_cell(8'd255);
		send_cell(8'd110);
		drain();
	endtask

	task automatic test_corner_grids();
		// zero sizes act as one
		set_config(8'h00, 11'd0, 11'd0);
		send_cell(8'h00);
		send_cell(8'hff);
		send_cell(8'h00);
		drain();
		// no free cell
		set_config(8'hff, 11'd2, 11'd2);
		repeat (4) send_cell(8'hff);
		drain();
		// all free 2x3: two equal squares, the first one wins
		set_config(8'hff, 11'd2, 11'd3);
		repeat (6) send_cell(8'h00);
		drain();
		// blocked center of a 3x3
		set_config(8'h5a, 11'd3, 11'd3);
		for (int i = 0; i < 9; i++)
			send_cell((i == 4) ? 8'h5a : 8'ha5);
		drain();
	endtask

	task automatic test_size_clamp();
		// columns past the maximum, only the last column free
		set_config(8'hd5, 11'd1, 11'd2047);
		repeat (MAX_COLS_DEF - 1) send_cell(8'hd5);
		send_cell(8'h00);
		drain();
	endtask

	task automatic test_random_grids();
		int    start, n_grids;
		char_t obs;
		start = cells_sent;
		while (cells_sent - start < 500) begin
			idle_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0: obs = 8'h00;
				1: obs = 8'hff;
				default: obs = char_t'($urandom_range(0, 255));
			endcase
			set_config(obs, pick_dim(), pick_dim());
			n_grids = $urandom_range(1, 6);
			for (int g = 0; g < n_grids && cells_sent - start < 500; g++)
				send_grid($urandom_range(0, 60));
			drain();
		end
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		set_config(char_t'($urandom_range(0, 255)), 11'd1, 11'd1);
		repeat (100) send_grid(30);
		drain();
		set_config(char_t'($urandom_range(0, 255)), 11'd4, 11'd5);
		repeat (4) send_grid($urandom_range(0, 40));
		drain();
	endtask

	// result side: random stall bursts while idling is on
	initial begin
		int hold;
		hold = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0)
				hold--;
			else if (idle_on && $urandom_range(0, 9) == 0)
				hold = $urandom_range(1, 15);
			res_if.ready <= (hold == 0);
		end
	end

	always @(posedge clk) begin
		square_t want;
		if (res_if.valid && res_if.ready) begin
			if (squares_due.size() == 0) begin
				report($sformatf("result with nothing due: side %0d at (%0d,%0d)",
					res_if.best_side, res_if.top_row, res_if.left_col));
			end else begin
				want = squares_due.pop_front();
				if (res_if.best_side !== want.side)
					report($sformatf("best_side got %0d want %0d",
						res_if.best_side, want.side));
				if (res_if.top_row !== want.row)
					report($sformatf("top_row got %0d want %0d", res_if.top_row, want.row));
				if (res_if.left_col !== want.col)
					report($sformatf("left_col got %0d want %0d",
						res_if.left_col, want.col));
			end
		end
	end

	initial begin
		#(64'd20_000_000);
		$display("largest_empty_square_dp: mismatch");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_OBSTACLE;
		cfg_data <= '0;
		cell_if.valid <= 1'b0;
		cell_if.cell_char <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_corner_grids();
		test_size_clamp();
		test_random_grids();
		test_full_rate();

		while (squares_due.size() != 0) begin
			want_left_over();
		end
		if (mismatches == 0)
			$display("largest_empty_square_dp: match");
		else
			$display("largest_empty_square_dp: mismatch");
		$finish;
	end

	task automatic want_left_over();
		square_t sq;
		sq = squares_due.pop_front();
		report($sformatf("square never came: side %0d at (%0d,%0d)", sq.side, sq.row, sq.col));
	endtask

endmodule
